[hdl/pat_pkg.sv]
// Package with shared types, codes and constants of the pending acknowledgement table.
`default_nettype none
package pat_pkg;

	// Default table depth and the maximum number of results from one sweep.
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

	// Timeout register value after reset, in milliseconds.
	localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

	// Request type codes.
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_ACK   = 2'd1;
	localparam logic [1:0] REQ_SWEEP = 2'd2;

	// Result status codes.
	localparam logic [2:0] STS_ADDED     = 3'd0;
	localparam logic [2:0] STS_FULL      = 3'd1;
	localparam logic [2:0] STS_REMOVED   = 3'd2;
	localparam logic [2:0] STS_NOT_FOUND = 3'd3;
	localparam logic [2:0] STS_EXPIRED   = 3'd4;
	localparam logic [2:0] STS_NONE      = 3'd5;

	// One table entry as held by a cell of the ring.
	typedef struct packed {
		logic        valid;
		logic [15:0] mod_id;
		logic [7:0]  cmd_id;
		logic [31:0] stamp;
	} entry_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] mod_id;
		logic [7:0]  cmd_id;
		logic        last;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_ACK_FIND,
		S_ACK_DEL,
		S_SWEEP,
		S_FINISH
	} state_t;

endpackage
`default_nettype wire

[hdl/pat_if.sv]
// Handshake interfaces for the request, result and timeout configuration channels.
`default_nettype none

// Request channel.
interface pat_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] mod_id;
	logic [7:0]  cmd_id;
	logic [31:0] now_ms;

	modport source (output valid, output req_type, output mod_id,
		output cmd_id, output now_ms, input ready);
	modport sink (input valid, input req_type, input mod_id,
		input cmd_id, input now_ms, output ready);
endinterface

// Result channel.
interface pat_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] module_uid_out;
	logic [7:0]  command_id_out;
	logic        last;

	modport source (output valid, output status, output module_uid_out,
		output command_id_out, output last, input ready);
	modport sink (input valid, input status, input module_uid_out,
		input command_id_out, input last, output ready);
endinterface

// Timeout register write channel.
interface pat_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/pat_cell.sv]
// One cell of the entry ring: holds one table entry and takes its neighbor's on a shift.
`default_nettype none
module pat_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           shift,
	input  wire pat_pkg::entry_t d,
	output pat_pkg::entry_t      q
);
	import pat_pkg::*;

	logic        valid_q;
	logic [15:0] module_q;
	logic [7:0]  command_q;
	logic [31:0] stamp_q;

	// The valid bit is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	// The key and stamp are only looked at while the valid bit is set.
	always_ff @(posedge clk) begin
		if (shift) begin
			module_q  <= d.mod_id;
			command_q <= d.cmd_id;
			stamp_q   <= d.stamp;
		end
	end

	assign q = '{valid: valid_q, mod_id: module_q, cmd_id: command_q, stamp: stamp_q};

endmodule
`default_nettype wire

[hdl/pending_ack_timeout_table.sv]
// Top level of the pending acknowledgement table: entry ring and request sequencer.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, mod_id, cmd_id, now_ms
//  rsp      out  valid/ready    status, module_uid_out, command_id_out, last
//  cfg      in   valid/ready    data (timeout_ms, 16 bits)
//
// The entries sit in a ring of TABLE_DEPTH cells that rotates by one slot per cycle while a
// request walks it, save while a sweep waits on a full result register; cell 0 is the only
// one inspected or changed. An add makes one pass of the ring, an ack one search pass and,
// when an entry matches, one removal pass, a sweep one pass; each then waits in its finish
// state for a free result register. One request is at work at a time. Reset empties the
// table at once and loads a timeout of 3000 ms.
`default_nettype none
module pending_ack_timeout_table #(
	parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pat_req_if.sink   req,
	pat_rsp_if.source rsp,
	pat_cfg_if.sink   cfg
);
	import pat_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	entry_t cell_q [TABLE_DEPTH];
	entry_t head;
	entry_t fb;
	logic   shift;

	state_t state_q, state_d;
	logic [IDX_W-1:0] step_q;
	logic [15:0] timeout_q;

	logic [1:0]  type_q;
	logic [15:0] mod_q;
	logic [7:0]  cmd_q;
	logic [31:0] now_q;

	logic             placed_q;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0]      best_age_q;
	logic             pend_q;
	logic [15:0]      pend_mod_q;
	logic [7:0]       pend_cmd_q;
	logic [CNT_W-1:0] n_q;

	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;
	logic load;

	logic [31:0] age;
	logic key_match, better, expired, last_step, out_free, place, accept;

	// Ring of cells: each takes its upper neighbor, the top one takes the head feedback.
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		if (g == TABLE_DEPTH - 1) begin : g_top
			pat_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(fb), .q(cell_q[g]));
		end else begin : g_mid
			pat_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(cell_q[g+1]),
				.q(cell_q[g]));
		end
	end

	assign head = cell_q[0];

	// Tests on the entry at the head of the ring.
	assign age       = now_q - head.stamp;
	assign key_match = head.valid && (head.mod_id == mod_q) && (head.cmd_id == cmd_q);
	assign better    = key_match && (!found_q || (age > best_age_q));
	assign expired   = head.valid && (age > {16'd0, timeout_q}) &&
		(n_q < CNT_W'(MAX_RESULTS));
	assign place     = !placed_q && !head.valid;
	assign last_step = (step_q == LAST_IDX);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, ring control, head feedback and result loading.
	always_comb begin
		state_d = state_q;
		shift   = 1'b0;
		fb      = head;
		load    = 1'b0;
		rsp_d   = '{status: STS_NONE, mod_id: mod_q, cmd_id: cmd_q, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						REQ_ADD:   state_d = S_ADD;
						REQ_ACK:   state_d = S_ACK_FIND;
						REQ_SWEEP: state_d = S_SWEEP;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				shift = 1'b1;
				if (place) begin
					fb = '{valid: 1'b1, mod_id: mod_q, cmd_id: cmd_q, stamp: now_q};
				end
				if (last_step) begin
					state_d = S_FINISH;
				end
			end
			S_ACK_FIND: begin
				shift = 1'b1;
				if (last_step) begin
					state_d = (found_q || better) ? S_ACK_DEL : S_FINISH;
				end
			end
			S_ACK_DEL: begin
				shift = 1'b1;
				if (step_q == best_idx_q) begin
					fb.valid = 1'b0;
				end
				if (last_step) begin
					state_d = S_FINISH;
				end
			end
			S_SWEEP: begin
				// A new expired entry pushes the one held back; wait if the output is full.
				if (expired && pend_q) begin
					shift = out_free;
					load  = out_free;
					rsp_d = '{status: STS_EXPIRED, mod_id: pend_mod_q,
						cmd_id: pend_cmd_q, last: 1'b0};
				end else begin
					shift = 1'b1;
				end
				if (expired) begin
					fb.valid = 1'b0;
				end
				if (last_step && shift) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				unique case (type_q)
					REQ_ADD: begin
						rsp_d.status = placed_q ? STS_ADDED : STS_FULL;
					end
					REQ_ACK: begin
						rsp_d.status = found_q ? STS_REMOVED : STS_NOT_FOUND;
					end
					default: begin
						if (pend_q) begin
							rsp_d = '{status: STS_EXPIRED, mod_id: pend_mod_q,
								cmd_id: pend_cmd_q, last: 1'b1};
						end else begin
							rsp_d = '{status: STS_NONE, mod_id: 16'd0,
								cmd_id: 8'd0, last: 1'b1};
						end
					end
				endcase
				if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer control registers and the timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			placed_q    <= 1'b0;
			found_q     <= 1'b0;
			pend_q      <= 1'b0;
			n_q         <= '0;
			rsp_valid_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
		end else begin
			if (cfg.valid) begin
				timeout_q <= cfg.data;
			end
			if (accept) begin
				step_q   <= '0;
				placed_q <= 1'b0;
				found_q  <= 1'b0;
				pend_q   <= 1'b0;
				n_q      <= '0;
			end
			if (shift) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
				if (state_q == S_ADD && place) begin
					placed_q <= 1'b1;
				end
				if (state_q == S_ACK_FIND && better) begin
					found_q <= 1'b1;
				end
				if (state_q == S_SWEEP && expired) begin
					pend_q <= 1'b1;
					n_q    <= n_q + 1'b1;
				end
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request copy, best match, held-back expired key, result.
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			mod_q  <= req.mod_id;
			cmd_q  <= req.cmd_id;
			now_q  <= req.now_ms;
		end
		if (shift && state_q == S_ACK_FIND && better) begin
			best_idx_q <= step_q;
			best_age_q <= age;
		end
		if (shift && state_q == S_SWEEP && expired) begin
			pend_mod_q <= head.mod_id;
			pend_cmd_q <= head.cmd_id;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_q.status;
	assign rsp.module_uid_out = rsp_q.mod_id;
	assign rsp.command_id_out = rsp_q.cmd_id;
	assign rsp.last           = rsp_q.last;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the pending acknowledgement table with its own table model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pat_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SEGMENT_ITEMS = 68;
	localparam logic [31:0] STAMP_BASE = 32'hFFFF_FF00;

	// One request as presented on the request channel.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] mod_id;
		logic [7:0]  cmd_id;
		logic [31:0] now_ms;
	} pat_request_t;

	// Tracks the table contents and the results that accepted requests still owe.
	class pending_table_model;
		bit          slot_used [DEPTH];
		logic [15:0] slot_module [DEPTH];
		logic [7:0]  slot_command [DEPTH];
		logic [31:0] slot_stamp [DEPTH];
		logic [15:0] timeout_cur;
		rsp_t        due[$];
		int          errors;

		function new();
			timeout_cur = TIMEOUT_RESET;
			errors = 0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		// Appends one owed result behind the others.
		function void owe(rsp_t item);
			due = {due, item};
		endfunction

		// Applies one accepted request to the table and queues the results it causes.
		function void note_request(pat_request_t r);
			int          best;
			int          n;
			logic [31:0] best_age;
			logic [31:0] age;
			rsp_t        item;
			best = -1;
			best_age = 32'd0;
			n = 0;
			case (r.kind)
				REQ_ADD: begin
					// The lowest free slot takes the new entry.
					for (int i = 0; i < DEPTH && best < 0; i++)
						if (!slot_used[i]) best = i;
					if (best >= 0) begin
						slot_used[best] = 1'b1;
						slot_module[best] = r.mod_id;
						slot_command[best] = r.cmd_id;
						slot_stamp[best] = r.now_ms;
						item = '{STS_ADDED, r.mod_id, r.cmd_id, 1'b1};
					end else begin
						item = '{STS_FULL, r.mod_id, r.cmd_id, 1'b1};
					end
					owe(item);
				end
				REQ_ACK: begin
					// The matching entry with the largest wrapped age goes; ties keep the lowest slot.
					for (int i = 0; i < DEPTH; i++) begin
						if (slot_used[i] && slot_module[i] == r.mod_id &&
								slot_command[i] == r.cmd_id) begin
							age = r.now_ms - slot_stamp[i];
							if (best < 0 || age > best_age) begin
								best = i;
								best_age = age;
							end
						end
					end
					if (best < 0) begin
						item = '{STS_NOT_FOUND, r.mod_id, r.cmd_id, 1'b1};
					end else begin
						slot_used[best] = 1'b0;
						item = '{STS_REMOVED, slot_module[best], slot_command[best], 1'b1};
					end
					owe(item);
				end
				REQ_SWEEP: begin
					// Expired entries leave in slot order; the final one carries last.
					for (int i = 0; i < DEPTH && n < MAX_RESULTS; i++) begin
						age = r.now_ms - slot_stamp[i];
						if (slot_used[i] && age > 32'(timeout_cur)) begin
							if (n > 0) owe(item);
							slot_used[i] = 1'b0;
							item = '{STS_EXPIRED, slot_module[i], slot_command[i], 1'b0};
							n++;
						end
					end
					if (n == 0) item = '{STS_NONE, 16'd0, 8'd0, 1'b1};
					else item.last = 1'b1;
					owe(item);
				end
				default: begin
					// The unused code leaves the table alone and gives no result.
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		// Compares one accepted result with the oldest owed result.
		function void check_result(rsp_t got);
			rsp_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result: expected nothing, actual %0h %0h %0h %0b",
					$time, got.status, got.mod_id, got.cmd_id, got.last);
				return;
			end
			want = due.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("module_uid_out", want.mod_id, got.mod_id);
			compare_field("command_id_out", want.cmd_id, got.cmd_id);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct = 21;
	int   sink_idle_pct = 63;
	int   cycle_count = 0;
	logic [31:0] clock_ms;
	logic [15:0] module_pool [2];
	logic [7:0]  command_pool [2];
	pending_table_model table_model = new();

	pat_req_if req_bus ();
	pat_rsp_if rsp_bus ();
	pat_cfg_if cfg_bus ();

	pending_ack_timeout_table #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Result side: check every accepted result and stall at random.
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			table_model.check_result('{rsp_bus.status, rsp_bus.module_uid_out,
				rsp_bus.command_id_out, rsp_bus.last});
		rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Presents one request after random idle cycles and notes it once accepted.
	task automatic send_request(input pat_request_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= r.kind;
		req_bus.mod_id <= r.mod_id;
		req_bus.cmd_id <= r.cmd_id;
		req_bus.now_ms <= r.now_ms;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		table_model.note_request(r);
	endtask

	// Holds off requests until every owed result is in, then optionally lets the block settle.
	task automatic drain_results(input bit settle);
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (table_model.due.size() != 0) @(posedge clk);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_module();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return module_pool[0];
			3: return module_pool[1];
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return command_pool[0];
			3: return command_pool[1];
			default: return 8'($urandom());
		endcase
	endfunction

	// Builds one random request; acks and sweeps often aim at entries that are in the table.
	function automatic pat_request_t make_request();
		pat_request_t r;
		int held[$];
		int roll;
		int slot;
		foreach (table_model.slot_used[i])
			if (table_model.slot_used[i]) held = {held, i};
		if ($urandom_range(99) < 3) clock_ms = $urandom();
		else clock_ms += $urandom_range(0, table_model.timeout_cur / 3 + 3);
		r.now_ms = clock_ms;
		r.mod_id = pick_module();
		r.cmd_id = pick_command();
		roll = $urandom_range(99);
		if (roll < 4) begin
			r.kind = REQ_UNUSED;
		end else if (roll < 44) begin
			r.kind = REQ_ADD;
		end else if (roll < 72) begin
			r.kind = REQ_ACK;
			if (held.size() > 0 && $urandom_range(99) < 75) begin
				slot = held[$urandom_range(0, held.size() - 1)];
				r.mod_id = table_model.slot_module[slot];
				r.cmd_id = table_model.slot_command[slot];
			end
		end else begin
			r.kind = REQ_SWEEP;
			// Some sweeps land right on the expiry boundary of an entry.
			if (held.size() > 0 && $urandom_range(99) < 30) begin
				slot = held[$urandom_range(0, held.size() - 1)];
				r.now_ms = table_model.slot_stamp[slot] + 32'(table_model.timeout_cur) +
					32'($urandom_range(0, 1));
			end
		end
		return r;
	endfunction

	// One phase: settle, write the timeout, then random requests with a full drain midway and others at random.
	task automatic run_segment(input logic [15:0] tmo, input int s_idle, input int k_idle);
		pat_request_t r;
		int sent;
		drain_results(1'b1);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= tmo;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		table_model.timeout_cur = tmo;
		src_idle_pct = s_idle;
		sink_idle_pct = k_idle;
		clock_ms = $urandom();
		sent = 0;
		while (sent < SEGMENT_ITEMS) begin
			if (sent == SEGMENT_ITEMS / 2 || $urandom_range(99) < 2) drain_results(1'b0);
			r = make_request();
			send_request(r);
			if (r.kind != REQ_UNUSED) sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_ADD;
		req_bus.mod_id = 16'd0;
		req_bus.cmd_id = 8'd0;
		req_bus.now_ms = 32'd0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = 16'd0;
		module_pool[0] = 16'($urandom());
		module_pool[1] = 16'($urandom());
		command_pool[0] = 8'($urandom());
		command_pool[1] = 8'($urandom());
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset timeout of 3000 ms.
		// Sweep of an empty table, then an ack that finds nothing.
		send_request('{REQ_SWEEP, 16'h0000, 8'h00, 32'd0});
		send_request('{REQ_ACK, 16'h0000, 8'h00, 32'd0});
		// Extreme keys and stamps, with duplicate keys stamped alike in slots 0 and 3.
		send_request('{REQ_ADD, 16'h0000, 8'h00, STAMP_BASE});
		send_request('{REQ_ADD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF});
		send_request('{REQ_ADD, 16'h0000, 8'h00, 32'd0});
		send_request('{REQ_ADD, 16'h0000, 8'h00, STAMP_BASE});
		send_request('{REQ_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF});
		// Equal ages across the wrap: the lower slot must go.
		send_request('{REQ_ACK, 16'h0000, 8'h00, 32'd100});
		// Age equal to the timeout stays, one more millisecond expires.
		send_request('{REQ_SWEEP, 16'h0000, 8'h00, STAMP_BASE + 32'd3000});
		send_request('{REQ_SWEEP, 16'hFFFF, 8'hFF, STAMP_BASE + 32'd3001});
		// Fill the table, overflow it, then expire all of it in one sweep.
		for (int k = 1; k <= 15; k++)
			send_request('{REQ_ADD, 16'(k * 16'h1111), 8'(k * 17), STAMP_BASE + 32'(3001 + k)});
		send_request('{REQ_SWEEP, 16'h0000, 8'h00, STAMP_BASE + 32'd100000});

		// Random phases over several timeouts, the extremes among them.
		run_segment(16'd1, 21, 63);
		run_segment(16'd65535, 21, 63);
		run_segment(16'd0, 63, 21);
		run_segment(16'($urandom_range(1, 65535)), 63, 21);
		run_segment(16'($urandom_range(50, 400)), 0, 0);
		run_segment(16'($urandom_range(1, 65535)), 0, 0);

		drain_results(1'b1);
		if (table_model.errors == 0 && table_model.due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

[pending_ack_timeout_table.f]
hdl/pat_pkg.sv
hdl/pat_if.sv
hdl/pat_cell.sv
hdl/pending_ack_timeout_table.sv
tb/tb_top.sv
